// ----- sv/sync_frame_receiver_fletcher_core_macros.svh -----
// Assertion macros shared by the frame receiver RTL.
`ifndef SYNC_FRAME_RECEIVER_FLETCHER_CORE_MACROS_SVH
`define SYNC_FRAME_RECEIVER_FLETCHER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define SFRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfrf check failed");
// Next-cycle implication, checked outside reset
`define SFRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfrf check failed");
`else
`define SFRF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SFRF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/sfrf_pkg.sv -----
// Shared types and constants for the sync frame receiver with Fletcher check.
package sfrf_pkg;

  localparam int TIMER_BITS = 32;
  localparam int TIMEOUT_W  = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BADCK   = 2'd2;
  localparam logic [1:0] KIND_CORRUPT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd3;

  // Reset values of the configuration registers
  localparam logic [7:0]           RST_FIRST_SYNC  = 8'd241;
  localparam logic [7:0]           RST_SECOND_SYNC = 8'd217;
  localparam logic [15:0]          RST_MAX_LEN     = 16'd950;
  localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT     = 32'd10000;

  typedef struct packed {
    logic [7:0]           first_sync;
    logic [7:0]           second_sync;
    logic [15:0]          max_len;
    logic [TIMEOUT_W-1:0] timeout;
  } cfg_t;

endpackage

// ----- sv/sfrf_if.sv -----
// Valid/ready channel interfaces for input beats and result beats.
interface sfrf_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface sfrf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  msg_group;
  logic [7:0]  sub_id;
  logic [7:0]  payload_byte;
  logic [15:0] byte_index;
  logic [15:0] payload_len;
  logic        last;

  modport source (output valid, output kind, output msg_group, output sub_id,
                  output payload_byte, output byte_index, output payload_len,
                  output last, input ready);
  modport sink   (input valid, input kind, input msg_group, input sub_id,
                  input payload_byte, input byte_index, input payload_len,
                  input last, output ready);
endinterface

// ----- sv/sync_frame_receiver_fletcher_core.sv -----
// Top level: sync frame receiver with running 8-bit Fletcher check.
// Output: a result beat is registered and appears in the cycle after the input beat that causes it.
// Throughput: one input beat per cycle; the result register clears its slot
// in the same cycle it is taken, so only a stalled result holds the input.
// Reset: synchronous active-low rst_n returns the parser to waiting for the
// first sync byte, clears frame state and loads the configuration defaults.
`include "sync_frame_receiver_fletcher_core_macros.svh"
module sync_frame_receiver_fletcher_core (
  input  logic                             clk,
  input  logic                             rst_n,
  sfrf_in_if.sink                          in_ch,
  sfrf_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [sfrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfrf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sfrf_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SYNC2, PH_GRP, PH_SUB, PH_LENLO, PH_LENHI, PH_DATA, PH_CKB
  } phase_t;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  cfg_t cfg;

  sfrf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Frame state
  phase_t                phase_r, phase_nxt;
  logic [7:0]            grp_r, grp_nxt;
  logic [7:0]            sub_r, sub_nxt;
  logic [15:0]           len_r, len_nxt;
  logic [15:0]           count_r, count_nxt;
  logic [7:0]            sum_a_r, sum_a_nxt;
  logic [7:0]            sum_b_r, sum_b_nxt;
  logic [7:0]            ck1_r, ck1_nxt;
  logic [TIMER_BITS-1:0] tick_r, tick_nxt;

  // Result register
  logic        out_valid_r;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [7:0]  ogrp_r;
  logic [7:0]  osub_r;
  logic [15:0] olen_r;
  logic        last_r, last_nxt;
  logic        res_valid;

  logic        in_fire;
  logic [7:0]  b;
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  // Fletcher step on the incoming byte
  assign add_a    = sum_a_r + b;
  assign add_b    = sum_b_r + add_a;
  assign len_full = {b, len_r[7:0]};

  // Advance the parser by one beat
  always_comb begin
    phase_nxt = phase_r;
    grp_nxt   = grp_r;
    sub_nxt   = sub_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    ck1_nxt   = ck1_r;
    tick_nxt  = tick_r;
    res_valid = 1'b0;
    kind_nxt  = KIND_CORRUPT;
    pbyte_nxt = 8'd0;
    idx_nxt   = 16'd0;
    last_nxt  = 1'b1;
    if (in_ch.operation == OP_TICK) begin
      if (phase_r != PH_IDLE) begin
        tick_nxt = (tick_r == TIMER_MAX) ? tick_r : tick_r + 1'b1;
        if (TIMEOUT_W'(tick_nxt) >= cfg.timeout) begin
          phase_nxt = PH_IDLE;
          res_valid = 1'b1;
        end
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (b == cfg.first_sync) begin
            phase_nxt = PH_SYNC2;
            grp_nxt   = 8'd0;
            sub_nxt   = 8'd0;
            len_nxt   = 16'd0;
            count_nxt = 16'd0;
            sum_a_nxt = 8'd0;
            sum_b_nxt = 8'd0;
            ck1_nxt   = 8'd0;
            tick_nxt  = '0;
          end
        end
        PH_SYNC2: begin
          if (b != cfg.second_sync) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
          end else begin
            phase_nxt = PH_GRP;
          end
        end
        PH_GRP: begin
          grp_nxt   = b;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = PH_SUB;
        end
        PH_SUB: begin
          sub_nxt   = b;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          len_nxt   = {8'd0, b};
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = PH_LENHI;
        end
        PH_LENHI: begin
          len_nxt   = len_full;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          if (len_full > cfg.max_len) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
          end else begin
            count_nxt = 16'd0;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if (count_r < len_r) begin
            sum_a_nxt = add_a;
            sum_b_nxt = add_b;
            count_nxt = count_r + 16'd1;
            res_valid = 1'b1;
            kind_nxt  = KIND_DATA;
            pbyte_nxt = b;
            idx_nxt   = count_r;
            last_nxt  = 1'b0;
          end else begin
            ck1_nxt   = b;
            phase_nxt = PH_CKB;
          end
        end
        PH_CKB: begin
          phase_nxt = PH_IDLE;
          res_valid = 1'b1;
          kind_nxt  = (ck1_r == sum_a_r && b == sum_b_r) ? KIND_GOOD : KIND_BADCK;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      grp_r       <= 8'd0;
      sub_r       <= 8'd0;
      len_r       <= 16'd0;
      count_r     <= 16'd0;
      sum_a_r     <= 8'd0;
      sum_b_r     <= 8'd0;
      ck1_r       <= 8'd0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        grp_r       <= grp_nxt;
        sub_r       <= sub_nxt;
        len_r       <= len_nxt;
        count_r     <= count_nxt;
        sum_a_r     <= sum_a_nxt;
        sum_b_r     <= sum_b_nxt;
        ck1_r       <= ck1_nxt;
        tick_r      <= tick_nxt;
        out_valid_r <= res_valid;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire && res_valid) begin
      kind_r  <= kind_nxt;
      pbyte_r <= pbyte_nxt;
      idx_r   <= idx_nxt;
      ogrp_r  <= grp_nxt;
      osub_r  <= sub_nxt;
      olen_r  <= len_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.msg_group    = ogrp_r;
  assign out_ch.sub_id       = osub_r;
  assign out_ch.payload_byte = pbyte_r;
  assign out_ch.byte_index   = idx_r;
  assign out_ch.payload_len  = olen_r;
  assign out_ch.last         = last_r;

  // Stalled result blocks new input
  `SFRF_ASSERT_NOW(a_stall_blocks_in, clk, rst_n, out_valid_r && !out_ch.ready, !in_ch.ready)
  // Only status beats close a frame
  `SFRF_ASSERT_NOW(a_last_is_status, clk, rst_n, out_valid_r, last_r == (kind_r != KIND_DATA))
  // Payload index stays inside the frame length
  `SFRF_ASSERT_NOW(a_index_in_len, clk, rst_n, out_valid_r && kind_r == KIND_DATA,
                   idx_r < olen_r)
  // Beats taken while idle produce no result
  `SFRF_ASSERT_NEXT(a_idle_silent, clk, rst_n, in_fire && phase_r == PH_IDLE, !out_valid_r)

endmodule

// ----- sv/sfrf_cfg_regs.sv -----
// Configuration register file of the frame receiver.
module sfrf_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sfrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfrf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output sfrf_pkg::cfg_t                   cfg
);
  import sfrf_pkg::*;

  cfg_t cfg_r;

  // Write the addressed register, restore defaults on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_sync  <= RST_FIRST_SYNC;
      cfg_r.second_sync <= RST_SECOND_SYNC;
      cfg_r.max_len     <= RST_MAX_LEN;
      cfg_r.timeout     <= RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_SYNC:  cfg_r.first_sync  <= cfg_wdata[7:0];
        CFG_SECOND_SYNC: cfg_r.second_sync <= cfg_wdata[7:0];
        CFG_MAX_LEN:     cfg_r.max_len     <= cfg_wdata[15:0];
        CFG_TIMEOUT:     cfg_r.timeout     <= cfg_wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the sync frame receiver with 8-bit Fletcher check.
`timescale 1ns / 100ps
module tb;
  import sfrf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 150;

  typedef enum logic [2:0] {
    ST_HUNT, ST_SYNC2, ST_GROUP, ST_SUB, ST_LEN_LO, ST_LEN_HI, ST_PAYLOAD, ST_CHECK_B
  } parse_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  msg_group;
    logic [7:0]  sub_id;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] payload_len;
    logic        last;
  } frame_beat_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  rx;
    logic        typed;
    frame_beat_t beat;
  } stim_row_t;

  localparam frame_beat_t NO_BEAT = '0;
  localparam frame_beat_t WRONG_SYNC2_STATUS =
    '{KIND_CORRUPT, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 1'b1};
  localparam frame_beat_t OVERLONG_STATUS =
    '{KIND_CORRUPT, 8'h01, 8'h02, 8'h00, 16'd0, 16'd951, 1'b1};

  // Directed rows, all under the reset configuration
  localparam stim_row_t DIRECTED [27] = '{
    // tick while hunting, then a wrong second sync that equals the first sync
    '{OP_TICK, 8'hFF, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'd241, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'd241, 1'b1, WRONG_SYNC2_STATUS},
    // the consumed byte must not restart a frame, so this one is dropped
    '{OP_BYTE, 8'd217, 1'b0, NO_BEAT},
    // zero-length frame with a bad check
    '{OP_BYTE, 8'd241, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'd217, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'hFF, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
    // one-byte frame with a good check
    '{OP_BYTE, 8'd241, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'd217, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h01, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h02, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h01, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'hFF, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h03, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h0F, 1'b0, NO_BEAT},
    // length one above the maximum
    '{OP_BYTE, 8'd241, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'd217, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h01, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h02, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'hB7, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h03, 1'b1, OVERLONG_STATUS}
  };

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sfrf_in_if  in_bus ();
  sfrf_out_if out_bus ();

  sync_frame_receiver_fletcher_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state and its copy of the registers
  cfg_t                  cfg_now;
  parse_state_t          parse_state;
  logic [7:0]            frame_grp, frame_sub, sum_a, sum_b, check_a_rx;
  logic [15:0]           frame_len, payload_seen;
  logic [TIMER_BITS-1:0] tick_total;

  frame_beat_t pending_frame_beats [$];

  bit gaps_on;
  int cycle_count, mismatch_count, result_count, counted_items;
  int payload_beats, good_frames, badck_frames, corrupt_frames;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  function automatic void fold_in(input logic [7:0] rx);
    sum_a = sum_a + rx;
    sum_b = sum_b + sum_a;
  endfunction

  // Advance the frame parser by one beat; return 1 when a result is due
  function automatic bit fletcher_frame_step(input logic op, input logic [7:0] rx,
                                             output frame_beat_t beat);
    bit emit;
    emit = 1'b0;
    beat = '0;
    if (op == OP_TICK) begin
      if (parse_state != ST_HUNT) begin
        if (tick_total != '1) tick_total++;
        if (tick_total >= cfg_now.timeout) begin
          emit = 1'b1;
          beat.kind = KIND_CORRUPT;
        end
      end
    end else begin
      case (parse_state)
        ST_HUNT: begin
          if (rx == cfg_now.first_sync) begin
            parse_state = ST_SYNC2;
            frame_grp = '0; frame_sub = '0; frame_len = '0; payload_seen = '0;
            sum_a = '0; sum_b = '0; check_a_rx = '0; tick_total = '0;
          end
        end
        ST_SYNC2: begin
          if (rx != cfg_now.second_sync) begin
            emit = 1'b1;
            beat.kind = KIND_CORRUPT;
          end else begin
            parse_state = ST_GROUP;
          end
        end
        ST_GROUP: begin
          frame_grp = rx;
          fold_in(rx);
          parse_state = ST_SUB;
        end
        ST_SUB: begin
          frame_sub = rx;
          fold_in(rx);
          parse_state = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          frame_len = {8'h00, rx};
          fold_in(rx);
          parse_state = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          frame_len[15:8] = rx;
          fold_in(rx);
          if (frame_len > cfg_now.max_len) begin
            emit = 1'b1;
            beat.kind = KIND_CORRUPT;
          end else begin
            payload_seen = '0;
            parse_state = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          if (payload_seen < frame_len) begin
            emit = 1'b1;
            beat.kind = KIND_DATA;
            beat.payload_byte = rx;
            beat.byte_index = payload_seen;
            fold_in(rx);
            payload_seen++;
          end else begin
            check_a_rx = rx;
            parse_state = ST_CHECK_B;
          end
        end
        default: begin
          emit = 1'b1;
          beat.kind = (check_a_rx == sum_a && rx == sum_b) ? KIND_GOOD : KIND_BADCK;
        end
      endcase
    end
    // Status beats close the frame
    if (emit) begin
      beat.msg_group = frame_grp;
      beat.sub_id = frame_sub;
      beat.payload_len = frame_len;
      if (beat.kind != KIND_DATA) begin
        beat.last = 1'b1;
        parse_state = ST_HUNT;
      end
    end
    return emit;
  endfunction

  // Offer one beat, with random gaps, and predict once it is taken
  task automatic send_beat(input logic op, input logic [7:0] rx, input bit typed,
                           input frame_beat_t typed_beat);
    frame_beat_t beat;
    bit          has_beat;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 30) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.operation <= op;
    in_bus.rx_byte <= rx;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (parse_state != ST_HUNT || (op == OP_BYTE && rx == cfg_now.first_sync))
      counted_items++;
    has_beat = fletcher_frame_step(op, rx, beat);
    if (typed) pending_frame_beats.push_back(typed_beat);
    else if (has_beat) pending_frame_beats.push_back(beat);
  endtask

  task automatic send_byte(input logic [7:0] rx);
    send_beat(OP_BYTE, rx, 1'b0, NO_BEAT);
  endtask

  task automatic maybe_tick(input int unsigned tick_pct);
    if ($urandom_range(99) < tick_pct) send_beat(OP_TICK, 8'($urandom_range(255)), 1'b0, NO_BEAT);
  endtask

  // One random frame: mostly well formed, else noise, broken or damaged
  task automatic send_random_frame(input int unsigned tick_pct);
    int unsigned pick, cap, stop_at;
    logic [15:0] len;
    logic [7:0]  sa, sb, ca, cb, rx;
    logic [7:0]  hdr [4];
    bit          overlong;
    pick = $urandom_range(99);
    if (pick >= 92) begin
      repeat ($urandom_range(1, 6))
        send_beat(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, NO_BEAT);
      return;
    end
    send_byte(cfg_now.first_sync);
    if (pick >= 84) begin
      send_byte(cfg_now.second_sync ^ 8'($urandom_range(1, 255)));
      return;
    end
    maybe_tick(tick_pct);
    send_byte(cfg_now.second_sync);
    overlong = (pick >= 76) && (cfg_now.max_len != 16'hFFFF);
    if (overlong) begin
      len = 16'(cfg_now.max_len + 1 + ($urandom % (65535 - cfg_now.max_len)));
    end else begin
      cap = ($urandom_range(99) < 4) ? 300 : 20;
      if (cap > cfg_now.max_len) cap = 32'(cfg_now.max_len);
      len = 16'($urandom_range(0, cap));
    end
    hdr = '{8'($urandom_range(255)), 8'($urandom_range(255)), len[7:0], len[15:8]};
    sa = '0;
    sb = '0;
    foreach (hdr[i]) begin
      sa = sa + hdr[i];
      sb = sb + sa;
      maybe_tick(tick_pct);
      send_byte(hdr[i]);
    end
    if (overlong) return;
    // Truncated frames stop early and leave the parser mid-frame
    stop_at = (pick >= 68) ? $urandom_range(0, len) : len + 1;
    for (int i = 0; i < len; i++) begin
      if (i == stop_at) return;
      rx = 8'($urandom_range(255));
      sa = sa + rx;
      sb = sb + sa;
      maybe_tick(tick_pct);
      send_byte(rx);
    end
    if (stop_at == len) return;
    ca = sa;
    cb = sb;
    if (pick >= 60 && pick < 68) begin
      if ($urandom_range(1)) ca ^= 8'(1 << $urandom_range(7));
      else cb ^= 8'(1 << $urandom_range(7));
    end
    maybe_tick(tick_pct);
    send_byte(ca);
    maybe_tick(tick_pct);
    send_byte(cb);
  endtask

  task automatic park_input();
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  // Wait for every expected result, then let the pipeline settle
  task automatic drain_results();
    while (pending_frame_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_FIRST_SYNC:  cfg_now.first_sync = data[7:0];
      CFG_SECOND_SYNC: cfg_now.second_sync = data[7:0];
      CFG_MAX_LEN:     cfg_now.max_len = data[15:0];
      CFG_TIMEOUT:     cfg_now.timeout = data[TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  // Program all registers with the input parked and all results drained, then run random frames
  task automatic run_phase(input cfg_t setting, input int budget, input int unsigned tick_pct);
    int start;
    park_input();
    drain_results();
    write_reg(CFG_FIRST_SYNC, CFG_DATA_W'(setting.first_sync));
    write_reg(CFG_SECOND_SYNC, CFG_DATA_W'(setting.second_sync));
    write_reg(CFG_MAX_LEN, CFG_DATA_W'(setting.max_len));
    write_reg(CFG_TIMEOUT, CFG_DATA_W'(setting.timeout));
    @(negedge clk);
    cfg_we <= 1'b0;
    start = counted_items;
    while (counted_items - start < budget) send_random_frame(tick_pct);
  endtask

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run timed out with %0d results outstanding", pending_frame_beats.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Drive ready with random stalls and one long hold-off
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && result_count >= HOLD_AFTER) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_bus.ready <= !(gaps_on && $urandom_range(99) < 30);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    frame_beat_t seen, want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen = '{out_bus.kind, out_bus.msg_group, out_bus.sub_id, out_bus.payload_byte,
               out_bus.byte_index, out_bus.payload_len, out_bus.last};
      result_count++;
      case (seen.kind)
        KIND_DATA:  payload_beats++;
        KIND_GOOD:  good_frames++;
        KIND_BADCK: badck_frames++;
        default:    corrupt_frames++;
      endcase
      if (pending_frame_beats.size() == 0) begin
        report_mismatch("unexpected result beat", 64'(seen), 64'd0);
      end else begin
        want = pending_frame_beats.pop_front();
        if (seen.kind !== want.kind)
          report_mismatch("kind", 64'(seen.kind), 64'(want.kind));
        if (seen.msg_group !== want.msg_group)
          report_mismatch("msg_group", 64'(seen.msg_group), 64'(want.msg_group));
        if (seen.sub_id !== want.sub_id)
          report_mismatch("sub_id", 64'(seen.sub_id), 64'(want.sub_id));
        if (seen.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", 64'(seen.payload_byte), 64'(want.payload_byte));
        if (seen.byte_index !== want.byte_index)
          report_mismatch("byte_index", 64'(seen.byte_index), 64'(want.byte_index));
        if (seen.payload_len !== want.payload_len)
          report_mismatch("payload_len", 64'(seen.payload_len), 64'(want.payload_len));
        if (seen.last !== want.last)
          report_mismatch("last", 64'(seen.last), 64'(want.last));
      end
    end
  end

  initial begin : stimulus
    in_bus.valid = 1'b0;
    in_bus.operation = OP_BYTE;
    in_bus.rx_byte = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_FIRST_SYNC;
    cfg_wdata = '0;
    rst_n = 1'b0;
    gaps_on = 1'b1;
    cfg_now = '{RST_FIRST_SYNC, RST_SECOND_SYNC, RST_MAX_LEN, RST_TIMEOUT};
    parse_state = ST_HUNT;
    frame_grp = '0; frame_sub = '0; frame_len = '0; payload_seen = '0;
    sum_a = '0; sum_b = '0; check_a_rx = '0; tick_total = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (DIRECTED[i]) send_beat(DIRECTED[i].op, DIRECTED[i].rx, DIRECTED[i].typed,
                                    DIRECTED[i].beat);

    run_phase('{RST_FIRST_SYNC, RST_SECOND_SYNC, RST_MAX_LEN, RST_TIMEOUT}, 450, 8);
    // Low extremes, no gaps on either side: zero-length frames, instant timeout
    gaps_on = 1'b0;
    run_phase('{8'h00, 8'hFF, 16'd0, 32'd0}, 350, 5);
    gaps_on = 1'b1;
    // High extremes: any length accepted, no timeout reachable in this run
    run_phase('{8'hFF, 8'h00, 16'hFFFF, 32'hFFFF_FFFF}, 550, 8);
    // Short limits so timeouts and overlong frames are frequent
    run_phase('{8'($urandom_range(255)), 8'($urandom_range(255)),
                16'($urandom_range(8, 40)), 32'($urandom_range(3, 20))}, 600, 20);

    park_input();
    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d frame-related beats over 4 register settings plus directed rows",
             counted_items);
    $display("results: %0d payload bytes, %0d good, %0d bad check, %0d corrupt or timed out",
             payload_beats, good_frames, badck_frames, corrupt_frames);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/sfrf_pkg.sv
sv/sfrf_if.sv
sv/sfrf_cfg_regs.sv
sv/sync_frame_receiver_fletcher_core.sv
tb/tb.sv
